// ----- rtl/kdll_pkg.sv -----
package kdll_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BITS_DEF  = 56;
    localparam int DATA_BITS_DEF = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage

// ----- rtl/keyed_doubly_linked_list_unit.sv -----
// Channel  Dir  tvalid/tready       tdata (low bit up)               tuser
// s_*      in   s_tvalid/s_tready   item_key, item_data, zero pad    opcode
// m_*      out  m_tvalid/m_tready   removed_data, entry_count, pad   status
//
// Append: S_ALLOC (reused freed slot only), then S_APPEND, then S_RESP loads the result.
// Remove: S_WALK to the match, then S_FREE and S_RESP; a miss walks the whole list.
// The walk does one key compare per cycle on the registered read of the slot stores.
// Reset clears state, ends, count, free/hwm and out_valid only; stores need no clearing.
// A result waits in the output register; a further finished result waits until it is taken.
module keyed_doubly_linked_list_unit
    import kdll_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // item_key, item_data, zero pad
    input  logic [((KEY_BITS+DATA_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // removed_data, entry_count, zero pad
    output logic [((DATA_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0] m_tuser
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ENT_W  = KEY_BITS + DATA_BITS;
    localparam int OUT_W  = ((DATA_BITS + CNT_W + 7) / 8) * 8;

    logic [SLOT_W-1:0]    rd_addr;
    logic                 ent_we;
    logic [SLOT_W-1:0]    ent_waddr;
    logic [ENT_W-1:0]     ent_wdata;
    logic [ENT_W-1:0]     ent_rdata;
    logic                 nxt_we;
    logic [SLOT_W-1:0]    nxt_waddr;
    logic [SLOT_W-1:0]    nxt_wdata;
    logic [SLOT_W-1:0]    nxt_rdata;
    logic                 prv_we;
    logic [SLOT_W-1:0]    prv_waddr;
    logic [SLOT_W-1:0]    prv_wdata;
    logic [SLOT_W-1:0]    prv_rdata;
    status_t              res_status;
    logic [DATA_BITS-1:0] res_removed;
    logic [CNT_W-1:0]     res_count;

    kdll_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tuser[0]),
        .in_key      (s_tdata[KEY_BITS-1:0]),
        .in_data     (s_tdata[KEY_BITS +: DATA_BITS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (res_status),
        .out_removed (res_removed),
        .out_count   (res_count),
        .rd_addr     (rd_addr),
        .ent_we      (ent_we),
        .ent_waddr   (ent_waddr),
        .ent_wdata   (ent_wdata),
        .ent_rdata   (ent_rdata),
        .nxt_we      (nxt_we),
        .nxt_waddr   (nxt_waddr),
        .nxt_wdata   (nxt_wdata),
        .nxt_rdata   (nxt_rdata),
        .prv_we      (prv_we),
        .prv_waddr   (prv_waddr),
        .prv_wdata   (prv_wdata),
        .prv_rdata   (prv_rdata)
    );

    kdll_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (rd_addr),
        .rdata (ent_rdata)
    );

    kdll_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    kdll_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    assign m_tdata = OUT_W'({res_count, res_removed});
    assign m_tuser = res_status;

endmodule

// ----- rtl/kdll_ram.sv -----
module kdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/kdll_ctrl.sv -----
module kdll_ctrl
    import kdll_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_opcode,
    input  logic [KEY_BITS-1:0]           in_key,
    input  logic [DATA_BITS-1:0]          in_data,
    // result side
    output logic                          out_valid,
    input  logic                          out_ready,
    output status_t                       out_status,
    output logic [DATA_BITS-1:0]          out_removed,
    output logic [$clog2(DEPTH+1)-1:0]    out_count,
    // shared read address for all stores
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    // entry store {key, payload}
    output logic                          ent_we,
    output logic [$clog2(DEPTH)-1:0]      ent_waddr,
    output logic [KEY_BITS+DATA_BITS-1:0] ent_wdata,
    input  logic [KEY_BITS+DATA_BITS-1:0] ent_rdata,
    // next links (also chain the free slots)
    output logic                          nxt_we,
    output logic [$clog2(DEPTH)-1:0]      nxt_waddr,
    output logic [$clog2(DEPTH)-1:0]      nxt_wdata,
    input  logic [$clog2(DEPTH)-1:0]      nxt_rdata,
    // prev links
    output logic                          prv_we,
    output logic [$clog2(DEPTH)-1:0]      prv_waddr,
    output logic [$clog2(DEPTH)-1:0]      prv_wdata,
    input  logic [$clog2(DEPTH)-1:0]      prv_rdata
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_APPEND,
        S_WALK,
        S_FREE,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [SLOT_W-1:0]    free_reg, free_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     hwm_reg, hwm_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    status_t              res_status_reg, res_status_next;
    logic [DATA_BITS-1:0] res_data_reg, res_data_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [DATA_BITS-1:0] out_removed_reg, out_removed_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    logic key_hit;
    logic at_first;
    logic at_last;

    assign key_hit  = (ent_rdata[DATA_BITS +: KEY_BITS] == key_reg);
    assign at_first = (pos_reg == '0);
    assign at_last  = ((pos_reg + ONE_CNT) == cnt_reg);

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_removed = out_removed_reg;
    assign out_count   = out_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        free_next        = free_reg;
        slot_next        = slot_reg;
        cnt_next         = cnt_reg;
        hwm_next         = hwm_reg;
        pos_next         = pos_reg;
        key_next         = key_reg;
        data_next        = data_reg;
        res_status_next  = res_status_reg;
        res_data_next    = res_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;

        rd_addr   = slot_reg;
        ent_we    = 1'b0;
        ent_waddr = slot_reg;
        ent_wdata = {key_reg, data_reg};
        nxt_we    = 1'b0;
        nxt_waddr = slot_reg;
        nxt_wdata = free_reg;
        prv_we    = 1'b0;
        prv_waddr = slot_reg;
        prv_wdata = tail_reg;

        case (state_reg)
            S_IDLE:
            begin
                // remove starts at the head; append may pop the free chain
                rd_addr = (in_opcode == OP_REMOVE) ? head_reg : free_reg;
                if (in_valid)
                begin
                    key_next      = in_key;
                    data_next     = in_data;
                    res_data_next = '0;
                    if (in_opcode == OP_APPEND)
                    begin
                        if (cnt_reg == FULL_CNT)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end
                        else if (cnt_reg < hwm_reg)
                        begin
                            slot_next  = free_reg;
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            slot_next  = hwm_reg[SLOT_W-1:0];
                            hwm_next   = hwm_reg + ONE_CNT;
                            state_next = S_APPEND;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            slot_next  = head_reg;
                            pos_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                free_next  = nxt_rdata;
                state_next = S_APPEND;
            end

            S_APPEND:
            begin
                ent_we = 1'b1;
                if (cnt_reg != '0)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = tail_reg;
                    nxt_wdata = slot_reg;
                    prv_we    = 1'b1;
                    prv_waddr = slot_reg;
                    prv_wdata = tail_reg;
                end
                else
                begin
                    head_next = slot_reg;
                end
                tail_next       = slot_reg;
                cnt_next        = cnt_reg + ONE_CNT;
                res_status_next = ST_DONE;
                state_next      = S_RESP;
            end

            S_WALK:
            begin
                // one compare per cycle; next address comes straight off the link store
                rd_addr = nxt_rdata;
                if (key_hit)
                begin
                    if (at_first)
                    begin
                        head_next = nxt_rdata;
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rdata;
                        nxt_wdata = nxt_rdata;
                    end
                    if (at_last)
                    begin
                        tail_next = prv_rdata;
                    end
                    else
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rdata;
                        prv_wdata = prv_rdata;
                    end
                    if (cnt_reg == ONE_CNT)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    cnt_next        = cnt_reg - ONE_CNT;
                    res_status_next = ST_DONE;
                    res_data_next   = ent_rdata[DATA_BITS-1:0];
                    state_next      = S_FREE;
                end
                else if (at_last)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    slot_next = nxt_rdata;
                    pos_next  = pos_reg + ONE_CNT;
                end
            end

            S_FREE:
            begin
                // push the released slot onto the free chain
                nxt_we     = 1'b1;
                nxt_waddr  = slot_reg;
                nxt_wdata  = free_reg;
                free_next  = slot_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_removed_next = res_data_reg;
                    out_count_next   = cnt_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            cnt_reg       <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        pos_reg         <= pos_next;
        key_reg         <= key_next;
        data_reg        <= data_next;
        res_status_reg  <= res_status_next;
        res_data_reg    <= res_data_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_le_hwm: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hwm_reg)
        else $error("entry count above allocated slots");

    a_hwm_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= FULL_CNT)
        else $error("slot high-water mark beyond depth");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (pos_reg < cnt_reg))
        else $error("walk ran past the list");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FULL) |-> (out_count_reg == FULL_CNT))
        else $error("full status with spare room");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && key_hit && cnt_reg == ONE_CNT)
            |=> (cnt_reg == '0 && head_reg == '0 && tail_reg == '0))
        else $error("last removal left list ends set");
`endif

endmodule
